@@ hdl/mss_pkg.sv @@
// Shared types and codes for the maintenance session supervisor.
package mss_pkg;

  // Event modes
  localparam logic [2:0] MODE_REQUEST  = 3'd0;
  localparam logic [2:0] MODE_HEALTH   = 3'd1;
  localparam logic [2:0] MODE_WATCHDOG = 3'd2;
  localparam logic [2:0] MODE_PERMIT   = 3'd3;
  localparam logic [2:0] MODE_PROGRESS = 3'd4;
  localparam logic [2:0] MODE_FAILURE  = 3'd5;
  localparam logic [2:0] MODE_COMPLETE = 3'd6;
  localparam logic [2:0] MODE_CANCEL   = 3'd7;

  // Failure codes
  localparam logic [2:0] FC_NONE           = 3'd0;
  localparam logic [2:0] FC_UNHEALTHY      = 3'd1;
  localparam logic [2:0] FC_DEADLINE       = 3'd2;
  localparam logic [2:0] FC_UNSAFE         = 3'd3;
  localparam logic [2:0] FC_TIMEOUT        = 3'd4;
  localparam logic [2:0] FC_BAD_PROGRESS   = 3'd5;
  localparam logic [2:0] FC_INVALID_TICKET = 3'd6;

  // Permit answers
  localparam logic [1:0] PERMIT_DENIED  = 2'd0;
  localparam logic [1:0] PERMIT_WAITING = 2'd1;
  localparam logic [1:0] PERMIT_READY   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_HARD_DEADLINE    = 1'b0;
  localparam logic CFG_PROGRESS_TIMEOUT = 1'b1;

  localparam logic [63:0] HARD_DEADLINE_RST    = 64'd10000000;
  localparam logic [63:0] PROGRESS_TIMEOUT_RST = 64'd1000000;

  typedef struct packed {
    logic [2:0]  mode;
    logic [63:0] now_time;
    logic [31:0] caller_ticket;
    logic [31:0] progress_value;
    logic        runtime_ok;
    logic        safe_now;
  } evt_t;

  typedef struct packed {
    logic        accepted;
    logic [31:0] issued_ticket;
    logic [1:0]  permit_code;
    logic [2:0]  failure_code;
    logic        busy_res;
  } res_t;

  typedef struct packed {
    logic [63:0] hard_deadline_us;
    logic [63:0] progress_timeout_us;
  } cfg_t;

endpackage

@@ hdl/maintenance_session_supervisor.sv @@
// A result appears in the output register in the cycle after its event transfer.
// Throughput: one event per cycle; the next event is taken while a result waits,
// as long as the output register is empty or being drained in the same cycle.
// Reset (async, active low): session idle, ticket counter zero, hard deadline
// 10000000 us, progress timeout 1000000 us, output register empty.
module maintenance_session_supervisor import mss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  evt_t        in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output res_t        out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  cfg_t cfg_q;
  logic out_valid_q;
  res_t out_data_q;
  res_t res;
  logic step;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign step       = in_valid_i && in_ready_o;

  mss_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .evt_i  (in_data_i),
    .cfg_i  (cfg_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hard_deadline_us    <= HARD_DEADLINE_RST;
      cfg_q.progress_timeout_us <= PROGRESS_TIMEOUT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_HARD_DEADLINE:    cfg_q.hard_deadline_us    <= cfg_wdata_i;
        CFG_PROGRESS_TIMEOUT: cfg_q.progress_timeout_us <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_data_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ hdl/mss_core.sv @@
// Session state and per-event decision logic.
module mss_core import mss_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  evt_t evt_i,
  input  cfg_t cfg_i,
  output res_t res_o
);

  localparam logic [2:0] PH_IDLE      = 3'd0;
  localparam logic [2:0] PH_REQUESTED = 3'd1;
  localparam logic [2:0] PH_APPROVED  = 3'd2;
  localparam logic [2:0] PH_ACTIVE    = 3'd3;
  localparam logic [2:0] PH_CANCELLED = 3'd4;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] ticket_q, ticket_d;
  logic [31:0] counter_q, counter_d;
  logic [31:0] mark_q, mark_d;
  logic [63:0] last_q, last_d;
  logic [63:0] deadline_q, deadline_d;
  logic [2:0]  failure_q, failure_d;

  logic        expired, tk_match, live, stale;
  logic        abort_en;
  logic [2:0]  abort_cause;
  logic [31:0] counter_inc;
  logic [64:0] deadline_sum;
  logic [64:0] gap;
  logic [63:0] deadline_new;

  assign expired  = (deadline_q == '0) || (evt_i.now_time > deadline_q);
  assign tk_match = (evt_i.caller_ticket != '0) && (evt_i.caller_ticket == ticket_q);
  assign live     = (phase_q != PH_IDLE) && (phase_q != PH_CANCELLED);

  assign counter_inc  = (counter_q == '1) ? 32'd1 : counter_q + 32'd1;
  assign deadline_sum = {1'b0, evt_i.now_time} + {1'b0, cfg_i.hard_deadline_us};
  assign deadline_new = deadline_sum[64] ? '1 : deadline_sum[63:0];

  // borrow in gap[64] means now is before the last progress time
  assign gap   = {1'b0, evt_i.now_time} - {1'b0, last_q};
  assign stale = (last_q == '0) || gap[64] || (gap[63:0] > cfg_i.progress_timeout_us);

  always_comb begin
    phase_d     = phase_q;
    ticket_d    = ticket_q;
    counter_d   = counter_q;
    mark_d      = mark_q;
    last_d      = last_q;
    deadline_d  = deadline_q;
    failure_d   = failure_q;
    abort_en    = 1'b0;
    abort_cause = FC_NONE;
    res_o       = '0;

    case (evt_i.mode)
      MODE_REQUEST: begin
        if (phase_q == PH_IDLE) begin
          counter_d  = counter_inc;
          ticket_d   = counter_inc;
          mark_d     = '0;
          last_d     = '0;
          failure_d  = FC_NONE;
          deadline_d = deadline_new;
          phase_d    = PH_REQUESTED;
          res_o.issued_ticket = counter_inc;
          res_o.accepted      = 1'b1;
        end
      end
      MODE_HEALTH: begin
        if (!evt_i.runtime_ok) begin
          if (phase_q != PH_IDLE) begin
            abort_en    = 1'b1;
            abort_cause = FC_UNHEALTHY;
          end
        end else if (phase_q == PH_IDLE) begin
          res_o.accepted = 1'b1;
        end else if (phase_q == PH_CANCELLED) begin
          res_o.accepted = 1'b0;
        end else if (expired) begin
          abort_en    = 1'b1;
          abort_cause = FC_DEADLINE;
        end else if (phase_q == PH_REQUESTED) begin
          if (evt_i.safe_now) phase_d = PH_APPROVED;
          res_o.accepted = 1'b1;
        end else if (!evt_i.safe_now) begin
          abort_en    = 1'b1;
          abort_cause = FC_UNSAFE;
        end else if (phase_q == PH_ACTIVE && stale) begin
          abort_en    = 1'b1;
          abort_cause = FC_TIMEOUT;
        end else begin
          res_o.accepted = 1'b1;
        end
      end
      MODE_WATCHDOG: begin
        if (phase_q == PH_APPROVED) begin
          if (!expired) begin
            phase_d = PH_ACTIVE;
            last_d  = evt_i.now_time;
          end else begin
            abort_en    = 1'b1;
            abort_cause = FC_DEADLINE;
          end
        end
      end
      MODE_PERMIT: begin
        if (tk_match && live) begin
          if (expired) begin
            abort_en    = 1'b1;
            abort_cause = FC_DEADLINE;
          end else begin
            res_o.permit_code = (phase_q == PH_ACTIVE) ? PERMIT_READY : PERMIT_WAITING;
          end
        end
      end
      MODE_PROGRESS: begin
        if (tk_match && live) begin
          if (expired) begin
            abort_en    = 1'b1;
            abort_cause = FC_DEADLINE;
          end else if (phase_q != PH_ACTIVE || evt_i.progress_value <= mark_q) begin
            abort_en    = 1'b1;
            abort_cause = FC_BAD_PROGRESS;
          end else begin
            mark_d         = evt_i.progress_value;
            last_d         = evt_i.now_time;
            res_o.accepted = 1'b1;
          end
        end
      end
      MODE_FAILURE: begin
        res_o.failure_code = tk_match ? failure_q : FC_INVALID_TICKET;
      end
      MODE_COMPLETE, MODE_CANCEL: begin
        if (tk_match && (evt_i.mode == MODE_CANCEL || phase_q != PH_IDLE)) begin
          ticket_d   = '0;
          mark_d     = '0;
          deadline_d = '0;
          last_d     = '0;
          phase_d    = PH_IDLE;
          failure_d  = FC_NONE;
        end
      end
      default: ;
    endcase

    if (abort_en) begin
      if (failure_q == FC_NONE) failure_d = abort_cause;
      phase_d = PH_CANCELLED;
    end

    res_o.busy_res = (phase_d != PH_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      ticket_q   <= '0;
      counter_q  <= '0;
      mark_q     <= '0;
      last_q     <= '0;
      deadline_q <= '0;
      failure_q  <= FC_NONE;
    end else if (step_i) begin
      phase_q    <= phase_d;
      ticket_q   <= ticket_d;
      counter_q  <= counter_d;
      mark_q     <= mark_d;
      last_q     <= last_d;
      deadline_q <= deadline_d;
      failure_q  <= failure_d;
    end
  end

  // A kept failure cause exists exactly while the session sits cancelled.
  a_failure_iff_cancelled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CANCELLED) == (failure_q != FC_NONE))
    else $error("failure cause out of step with phase");

  // An open session always holds a nonzero ticket.
  a_ticket_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_IDLE) |-> (ticket_q != '0))
    else $error("open session without ticket");

  // A granted request opens a session with the ticket it reported.
  a_request_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && evt_i.mode == MODE_REQUEST && phase_q == PH_IDLE)
      |=> (phase_q == PH_REQUESTED && ticket_q == $past(res_o.issued_ticket)))
    else $error("request did not open session");

endmodule

@@ dv/maintenance_session_checker.sv @@
// Scoreboard for the maintenance session supervisor: predicts every event's result and checks it.
`timescale 1ns / 100ps
module maintenance_session_checker import mss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  evt_t        in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  res_t        out_data_i,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  output int          error_count_o,
  output int          results_owed_o
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_REQUESTED,
    PH_APPROVED,
    PH_ACTIVE,
    PH_CANCELLED
  } phase_e;

  phase_e      phase;
  logic [31:0] cur_ticket;
  logic [31:0] ticket_ctr;
  logic [31:0] mark;
  logic [63:0] last_prog_us;
  logic [63:0] deadline_us;
  logic [2:0]  first_fail;
  logic [63:0] hard_deadline_us;
  logic [63:0] prog_timeout_us;

  res_t owed_q[$];
  res_t want;

  function automatic void close_session();
    cur_ticket   = '0;
    mark         = '0;
    deadline_us  = '0;
    last_prog_us = '0;
    phase        = PH_IDLE;
    first_fail   = FC_NONE;
  endfunction

  // only the first cause sticks
  function automatic void fail_session(logic [2:0] cause);
    if (first_fail == FC_NONE) first_fail = cause;
    phase = PH_CANCELLED;
  endfunction

  function automatic logic deadline_passed(logic [63:0] now);
    return (deadline_us == '0) || (now > deadline_us);
  endfunction

  function automatic logic ticket_ok(logic [31:0] tk);
    return (tk != '0) && (tk == cur_ticket);
  endfunction

  function automatic logic session_open();
    return (phase != PH_IDLE) && (phase != PH_CANCELLED);
  endfunction

  function automatic res_t session_result(evt_t ev);
    res_t r;
    r = '0;
    case (ev.mode)
      MODE_REQUEST: begin
        if (phase == PH_IDLE) begin
          ticket_ctr = ticket_ctr + 32'd1;
          if (ticket_ctr == '0) ticket_ctr = 32'd1;
          cur_ticket   = ticket_ctr;
          mark         = '0;
          last_prog_us = '0;
          first_fail   = FC_NONE;
          // saturating add
          deadline_us = (ev.now_time > ~hard_deadline_us) ? '1 : ev.now_time + hard_deadline_us;
          phase = PH_REQUESTED;
          r.issued_ticket = cur_ticket;
          r.accepted      = 1'b1;
        end
      end
      MODE_HEALTH: begin
        if (!ev.runtime_ok) begin
          if (phase != PH_IDLE) fail_session(FC_UNHEALTHY);
        end else if (phase == PH_IDLE) begin
          r.accepted = 1'b1;
        end else if (phase == PH_CANCELLED) begin
          r.accepted = 1'b0;
        end else if (deadline_passed(ev.now_time)) begin
          fail_session(FC_DEADLINE);
        end else if (phase == PH_REQUESTED) begin
          if (ev.safe_now) phase = PH_APPROVED;
          r.accepted = 1'b1;
        end else if (!ev.safe_now) begin
          fail_session(FC_UNSAFE);
        end else if (phase == PH_ACTIVE && (last_prog_us == '0 || ev.now_time < last_prog_us ||
                     ev.now_time - last_prog_us > prog_timeout_us)) begin
          fail_session(FC_TIMEOUT);
        end else begin
          r.accepted = 1'b1;
        end
      end
      MODE_WATCHDOG: begin
        if (phase == PH_APPROVED) begin
          if (!deadline_passed(ev.now_time)) begin
            phase        = PH_ACTIVE;
            last_prog_us = ev.now_time;
          end else begin
            fail_session(FC_DEADLINE);
          end
        end
      end
      MODE_PERMIT: begin
        if (ticket_ok(ev.caller_ticket) && session_open()) begin
          if (deadline_passed(ev.now_time)) begin
            fail_session(FC_DEADLINE);
          end else begin
            r.permit_code = (phase == PH_ACTIVE) ? PERMIT_READY : PERMIT_WAITING;
          end
        end
      end
      MODE_PROGRESS: begin
        if (ticket_ok(ev.caller_ticket) && session_open()) begin
          if (deadline_passed(ev.now_time)) begin
            fail_session(FC_DEADLINE);
          end else if (phase != PH_ACTIVE || ev.progress_value <= mark) begin
            fail_session(FC_BAD_PROGRESS);
          end else begin
            mark         = ev.progress_value;
            last_prog_us = ev.now_time;
            r.accepted   = 1'b1;
          end
        end
      end
      MODE_FAILURE: begin
        r.failure_code = ticket_ok(ev.caller_ticket) ? first_fail : FC_INVALID_TICKET;
      end
      MODE_COMPLETE: begin
        if (ticket_ok(ev.caller_ticket) && phase != PH_IDLE) close_session();
      end
      MODE_CANCEL: begin
        if (ticket_ok(ev.caller_ticket)) close_session();
      end
      default: ;
    endcase
    r.busy_res = (phase != PH_IDLE);
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, actual %0h", name, exp_val, act_val);
      error_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hard_deadline_us = HARD_DEADLINE_RST;
      prog_timeout_us  = PROGRESS_TIMEOUT_RST;
      ticket_ctr       = '0;
      close_session();
      owed_q.delete();
      error_count_o = 0;
      results_owed_o <= 0;
    end else begin
      // result transfer first: it always belongs to an older event
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          $error("result %p arrived with nothing outstanding", out_data_i);
          error_count_o++;
        end else begin
          want = owed_q.pop_front();
          check_field("accepted", 64'(want.accepted), 64'(out_data_i.accepted));
          check_field("issued_ticket", 64'(want.issued_ticket),
                      64'(out_data_i.issued_ticket));
          check_field("permit_code", 64'(want.permit_code), 64'(out_data_i.permit_code));
          check_field("failure_code", 64'(want.failure_code), 64'(out_data_i.failure_code));
          check_field("busy_res", 64'(want.busy_res), 64'(out_data_i.busy_res));
        end
      end
      if (in_valid_i && in_ready_i) owed_q.push_back(session_result(in_data_i));
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HARD_DEADLINE:    hard_deadline_us = cfg_wdata_i;
          CFG_PROGRESS_TIMEOUT: prog_timeout_us  = cfg_wdata_i;
          default: ;
        endcase
      end
      results_owed_o <= owed_q.size();
    end
  end

endmodule

@@ dv/maintenance_session_supervisor_tb.sv @@
// Testbench top for the maintenance session supervisor: stimulus, flow control and verdict.
`timescale 1ns / 100ps
module maintenance_session_supervisor_tb import mss_pkg::*; ();

  localparam logic [63:0] TIME_MAX = '1;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        ev_valid = 1'b0;
  logic        ev_ready;
  evt_t        ev_data = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res_data;
  logic        cfg_we = 1'b0;
  logic        cfg_idx = CFG_HARD_DEADLINE;
  logic [63:0] cfg_wdata = '0;

  int          error_count;
  int          results_owed;
  int          send_idle_pct = 19;
  int          recv_idle_pct = 86;
  int          events_sent = 0;
  logic [31:0] live_ticket = '0;
  logic [63:0] now_us = '0;
  logic [63:0] deadline_setting = HARD_DEADLINE_RST;
  logic [63:0] timeout_setting = PROGRESS_TIMEOUT_RST;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  maintenance_session_supervisor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (ev_valid),
    .in_ready_o  (ev_ready),
    .in_data_i   (ev_data),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .out_data_o  (res_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  maintenance_session_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (ev_valid),
    .in_ready_i     (ev_ready),
    .in_data_i      (ev_data),
    .out_valid_i    (res_valid),
    .out_ready_i    (res_ready),
    .out_data_i     (res_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .error_count_o  (error_count),
    .results_owed_o (results_owed)
  );

  always @(posedge clk) begin
    res_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // latest granted ticket, so sessions can present it
  always @(posedge clk) begin
    if (res_valid && res_ready && res_data.issued_ticket != '0)
      live_ticket <= res_data.issued_ticket;
  end

  function automatic evt_t make_evt(logic [2:0] mode, logic [63:0] at, logic [31:0] tk,
                                    logic [31:0] prog, logic ok, logic safe);
    evt_t e;
    e.mode           = mode;
    e.now_time       = at;
    e.caller_ticket  = tk;
    e.progress_value = prog;
    e.runtime_ok     = ok;
    e.safe_now       = safe;
    return e;
  endfunction

  // advance the session clock; mostly small steps, sometimes past a timeout or backwards
  function automatic logic [63:0] tick();
    logic [31:0] gap_hint;
    logic [31:0] dl_hint;
    gap_hint = (timeout_setting > 64'd200000) ? 32'd200000 : timeout_setting[31:0];
    dl_hint  = (deadline_setting > 64'd400000) ? 32'd400000 : deadline_setting[31:0];
    case ($urandom_range(19))
      0: ;
      1: now_us = now_us - 64'($urandom_range(1, 50));
      2: now_us = now_us + 64'(gap_hint) + 64'($urandom_range(1, 100));
      3: now_us = now_us + 64'($urandom_range(0, 2 * dl_hint));
      default: now_us = now_us + 64'($urandom_range(0, gap_hint));
    endcase
    return now_us;
  endfunction

  function automatic evt_t noise_evt(logic [31:0] tk);
    evt_t e;
    e.mode           = 3'($urandom_range(7));
    e.now_time       = $urandom_range(1) ? now_us : {$urandom, $urandom};
    case ($urandom_range(3))
      0: e.caller_ticket = '0;
      1: e.caller_ticket = $urandom;
      default: e.caller_ticket = tk;
    endcase
    e.progress_value = $urandom;
    e.runtime_ok     = 1'($urandom_range(1));
    e.safe_now       = 1'($urandom_range(1));
    return e;
  endfunction

  task automatic send_evt(evt_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      ev_valid <= 1'b0;
      @(posedge clk);
    end
    ev_valid <= 1'b1;
    ev_data  <= e;
    @(posedge clk);
    while (!ev_ready) @(posedge clk);
    events_sent++;
  endtask

  task automatic send_mixed(evt_t e, logic [31:0] tk);
    if ($urandom_range(99) < 10) send_evt(noise_evt(tk));
    else send_evt(e);
  endtask

  // hold off until every outstanding result has been transferred
  task automatic settle();
    ev_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  task automatic write_regs(logic [63:0] hard, logic [63:0] gap);
    settle();
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_HARD_DEADLINE;
    cfg_wdata <= hard;
    @(posedge clk);
    cfg_idx   <= CFG_PROGRESS_TIMEOUT;
    cfg_wdata <= gap;
    @(posedge clk);
    cfg_we <= 1'b0;
    deadline_setting = hard;
    timeout_setting  = gap;
  endtask

  task automatic run_session();
    logic [31:0] tk;
    logic [31:0] level;
    int          steps;
    settle();
    // close whatever is still open
    send_evt(make_evt(MODE_CANCEL, now_us, live_ticket, '0, 1'b1, 1'b1));
    case ($urandom_range(3))
      0: now_us = {$urandom, $urandom};
      1: now_us = TIME_MAX - 64'($urandom_range(0, 100000));
      default: now_us = 64'($urandom_range(0, 1000000));
    endcase
    send_evt(make_evt(MODE_REQUEST, now_us, $urandom, $urandom, 1'($urandom_range(1)),
                      1'($urandom_range(1))));
    settle();
    tk = live_ticket;
    send_mixed(make_evt(MODE_HEALTH, tick(), tk, '0, $urandom_range(19) != 0,
                        $urandom_range(2) != 0), tk);
    send_mixed(make_evt(MODE_HEALTH, tick(), tk, '0, 1'b1, 1'b1), tk);
    send_mixed(make_evt(MODE_WATCHDOG, tick(), tk, '0, 1'b1, 1'b1), tk);
    level = '0;
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      case ($urandom_range(11))
        0: ;
        1: level = level >> 1;
        default: level = level + $urandom_range(1, 1000);
      endcase
      send_mixed(make_evt(MODE_PROGRESS, tick(), tk, level, 1'b1, 1'b1), tk);
      case ($urandom_range(4))
        0: send_mixed(make_evt(MODE_HEALTH, tick(), tk, '0, $urandom_range(24) != 0,
                               $urandom_range(12) != 0), tk);
        1: send_mixed(make_evt(MODE_PERMIT, tick(), tk, '0, 1'b1, 1'b1), tk);
        2: send_mixed(make_evt(MODE_FAILURE, now_us, tk, '0, 1'b1, 1'b1), tk);
        default: ;
      endcase
    end
    send_evt(make_evt(MODE_FAILURE, now_us, tk, '0, 1'b1, 1'b1));
    case ($urandom_range(2))
      0: send_mixed(make_evt(MODE_COMPLETE, tick(), tk, '0, 1'b1, 1'b1), tk);
      1: send_mixed(make_evt(MODE_CANCEL, tick(), tk, '0, 1'b1, 1'b1), tk);
      default: begin
        send_evt(make_evt(MODE_COMPLETE, now_us, tk + 32'd1, '0, 1'b1, 1'b1));
        send_evt(make_evt(MODE_CANCEL, now_us, tk, '0, 1'b1, 1'b1));
      end
    endcase
  endtask

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [31:0] tk;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // full session walk with reset settings, then refusals and bad progress
    send_evt(make_evt(MODE_REQUEST, 64'd100, '0, '0, 1'b1, 1'b1));
    settle();
    tk = live_ticket;
    send_evt(make_evt(MODE_REQUEST, 64'd150, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PERMIT, 64'd160, '0, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PERMIT, 64'd170, tk + 32'd1, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PERMIT, 64'd200, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_HEALTH, 64'd300, tk, '0, 1'b1, 1'b0));
    send_evt(make_evt(MODE_HEALTH, 64'd400, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_WATCHDOG, 64'd500, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PROGRESS, 64'd600, tk, 32'd5, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PERMIT, 64'd650, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PROGRESS, 64'd700, tk, 32'd5, 1'b1, 1'b1));
    send_evt(make_evt(MODE_FAILURE, 64'd710, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_HEALTH, 64'd720, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_COMPLETE, 64'd730, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_HEALTH, 64'd740, tk, '0, 1'b0, 1'b0));
    send_evt(make_evt(MODE_FAILURE, 64'd750, '0, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_CANCEL, 64'd760, tk + 32'd1, '0, 1'b1, 1'b1));

    // deadline saturates near the top of the time range
    send_evt(make_evt(MODE_REQUEST, TIME_MAX - 64'd5, '0, '1, 1'b0, 1'b0));
    settle();
    tk = live_ticket;
    send_evt(make_evt(MODE_HEALTH, TIME_MAX - 64'd4, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_WATCHDOG, TIME_MAX - 64'd3, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_PROGRESS, TIME_MAX, tk, '1, 1'b1, 1'b1));
    send_evt(make_evt(MODE_HEALTH, TIME_MAX, tk, '0, 1'b0, 1'b1));
    send_evt(make_evt(MODE_FAILURE, TIME_MAX, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_CANCEL, TIME_MAX, tk, '0, 1'b1, 1'b1));

    // zero hard deadline: stored deadline of zero is already expired
    write_regs('0, PROGRESS_TIMEOUT_RST);
    send_evt(make_evt(MODE_REQUEST, '0, '0, '0, 1'b1, 1'b1));
    settle();
    tk = live_ticket;
    send_evt(make_evt(MODE_HEALTH, '0, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_FAILURE, '0, tk, '0, 1'b1, 1'b1));
    send_evt(make_evt(MODE_CANCEL, '0, tk, '0, 1'b1, 1'b1));
    now_us = 64'd1000;

    for (int blk = 0; blk < 9; blk++) begin
      if (blk == 3) begin
        send_idle_pct = 86;
        recv_idle_pct = 19;
      end
      if (blk == 6) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      case (blk % 4)
        0: write_regs(64'($urandom_range(2000, 50000)), 64'($urandom_range(50, 2000)));
        1: write_regs('1, '1);
        2: write_regs(64'($urandom_range(500, 20000)), '0);
        default: write_regs(64'($urandom_range(1, 300)), 64'($urandom_range(20, 200)));
      endcase
      while (events_sent < 30 + 100 * (blk + 1)) run_session();
    end

    settle();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ files.f @@
hdl/mss_pkg.sv
hdl/mss_core.sv
hdl/maintenance_session_supervisor.sv
dv/maintenance_session_checker.sv
dv/maintenance_session_supervisor_tb.sv
